// ===== rtl/tir_pkg.sv =====
// tir_pkg: shared widths, register indexes and command codes for the tiled index remapper
// no dependencies
package tir_pkg;

  // default index width of the input channel
  localparam int DEF_INDEX_BITS = 16;

  // result width, fixed by the output field
  localparam int OUT_W = 17;

  // configuration register widths
  localparam int GA_W = 9;
  localparam int CW_W = 5;
  localparam int CH_W = 5;

  // derived sizes: row length (tiles across times tile width) and tile area
  localparam int GW_W = GA_W + CW_W;
  localparam int WH_W = CW_W + CH_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GA_W;

  localparam logic [CFG_IDX_W-1:0] REG_GROUPS_ACROSS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT   = 2'd2;

  // request commands
  localparam logic CMD_FLAT_TO_GROUPED = 1'b0;
  localparam logic CMD_GROUPED_TO_FLAT = 1'b1;

endpackage

// ===== rtl/tiled_index_remap.sv =====
// tiled_index_remap: top level, converts indices between raster and tile-major order
// depends on tir_pkg for widths, register indexes and command codes
//
// usage
//   input channel  : in_valid / in_stall, payload in_command and in_index
//                    command 0 maps a raster index to tile-major, command 1 the reverse
//   result channel : out_valid / out_stall, payload out_mapped_index (17 bits, wraps)
//   config port    : cfg_we / cfg_index / cfg_data, groups across, cell width and
//                    cell height; a written zero counts as one; only while idle
// throughput: one request per cycle while in_stall is low
// pipeline: input register, then the two restoring dividers, each retiring one
//   quotient bit per stage, then four multiply/add stages and the output register
// reset: synchronous, active low; all stage valid bits clear, sizes return to one
// stall: the output register and a one-entry skid register sit behind the pipe;
//   a new request is still taken while a result waits, and in_stall rises only
//   once the skid register is full, at which point the whole pipe holds
module tiled_index_remap
  import tir_pkg::*;
#(
  parameter int INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_command,
  input  logic [INDEX_BITS-1:0] in_index,

  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OUT_W-1:0]      out_mapped_index
);

  // second divider pass runs over the wider of the quotient and the row remainder
  localparam int P2 = (INDEX_BITS > GW_W) ? INDEX_BITS : GW_W;

  // ---------------------------------------------------------------------------
  // configuration, zero stored as one so every divisor is non-zero
  // ---------------------------------------------------------------------------
  logic [GA_W-1:0] ga_r;
  logic [CW_W-1:0] cw_r;
  logic [CH_W-1:0] ch_r;
  logic [GW_W-1:0] gw_r;   // row length in cells
  logic [WH_W-1:0] wh_r;   // cells per tile

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ga_r <= GA_W'(1);
      cw_r <= CW_W'(1);
      ch_r <= CH_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GROUPS_ACROSS: ga_r <= (cfg_data == '0) ? GA_W'(1) : cfg_data;
        REG_CELL_WIDTH:    ga_r <= ga_r;
        REG_CELL_HEIGHT:   ga_r <= ga_r;
        default:           ga_r <= ga_r;
      endcase
      if (cfg_index == REG_CELL_WIDTH) begin
        cw_r <= (cfg_data[CW_W-1:0] == '0) ? CW_W'(1) : cfg_data[CW_W-1:0];
      end
      if (cfg_index == REG_CELL_HEIGHT) begin
        ch_r <= (cfg_data[CH_W-1:0] == '0) ? CH_W'(1) : cfg_data[CH_W-1:0];
      end
    end
  end

  // products are registered from the size registers in the next cycle, before any request reaches them
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GW_W'(1);
      wh_r <= WH_W'(1);
    end else begin
      gw_r <= GW_W'(ga_r) * GW_W'(cw_r);
      wh_r <= WH_W'(cw_r) * WH_W'(ch_r);
    end
  end

  // ---------------------------------------------------------------------------
  // pipe enable: everything advances while the skid register is empty
  // ---------------------------------------------------------------------------
  logic skid_v_r;
  logic en;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // input register
  logic                  in_v_r;
  logic                  in_cmd_r;
  logic [INDEX_BITS-1:0] in_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_cmd_r <= in_command;
      in_idx_r <= in_index;
    end
  end

  // ---------------------------------------------------------------------------
  // first divider: index by row length (raster) or tile area (tile-major)
  // one quotient bit per stage, msb first
  // ---------------------------------------------------------------------------
  logic                  p1_v_r   [INDEX_BITS];
  logic                  p1_cmd_r [INDEX_BITS];
  logic [GW_W-1:0]       p1_rem_r [INDEX_BITS];
  logic [INDEX_BITS-1:0] p1_num_r [INDEX_BITS];

  for (genvar s = 0; s < INDEX_BITS; s++) begin : g_p1
    logic                  src_v;
    logic                  src_cmd;
    logic [GW_W-1:0]       src_rem;
    logic [INDEX_BITS-1:0] src_num;
    logic [GW_W-1:0]       div;
    logic [GW_W:0]         trial;
    logic [GW_W:0]         diff;
    logic                  ge;

    if (s == 0) begin : g_first
      assign src_v   = in_v_r;
      assign src_cmd = in_cmd_r;
      assign src_rem = '0;
      assign src_num = in_idx_r;
    end else begin : g_next
      assign src_v   = p1_v_r[s-1];
      assign src_cmd = p1_cmd_r[s-1];
      assign src_rem = p1_rem_r[s-1];
      assign src_num = p1_num_r[s-1];
    end

    always_comb begin
      div   = (src_cmd == CMD_GROUPED_TO_FLAT) ? GW_W'(wh_r) : gw_r;
      trial = {src_rem, src_num[INDEX_BITS-1]};
      diff  = trial - {1'b0, div};
      ge    = (trial >= {1'b0, div});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p1_v_r[s] <= 1'b0;
      end else if (en) begin
        p1_v_r[s] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p1_cmd_r[s] <= src_cmd;
        p1_rem_r[s] <= ge ? diff[GW_W-1:0] : trial[GW_W-1:0];
        p1_num_r[s] <= {src_num[INDEX_BITS-2:0], ge};
      end
    end
  end

  // ---------------------------------------------------------------------------
  // second pass, two dividers side by side
  //   a: first quotient by cell height (raster) or groups across (tile-major)
  //   b: first remainder by cell width
  // ---------------------------------------------------------------------------
  logic            p2_v_r   [P2];
  logic            p2_cmd_r [P2];
  logic [P2-1:0]   p2_qa_r  [P2];
  logic [GA_W-1:0] p2_ra_r  [P2];
  logic [P2-1:0]   p2_qb_r  [P2];
  logic [CW_W-1:0] p2_rb_r  [P2];

  for (genvar t = 0; t < P2; t++) begin : g_p2
    logic            src_v;
    logic            src_cmd;
    logic [P2-1:0]   src_qa;
    logic [GA_W-1:0] src_ra;
    logic [P2-1:0]   src_qb;
    logic [CW_W-1:0] src_rb;
    logic [GA_W-1:0] div_a;
    logic [GA_W:0]   trial_a;
    logic [GA_W:0]   diff_a;
    logic            ge_a;
    logic [CW_W:0]   trial_b;
    logic [CW_W:0]   diff_b;
    logic            ge_b;

    if (t == 0) begin : g_first
      assign src_v   = p1_v_r[INDEX_BITS-1];
      assign src_cmd = p1_cmd_r[INDEX_BITS-1];
      assign src_qa  = P2'(p1_num_r[INDEX_BITS-1]);
      assign src_ra  = '0;
      assign src_qb  = P2'(p1_rem_r[INDEX_BITS-1]);
      assign src_rb  = '0;
    end else begin : g_next
      assign src_v   = p2_v_r[t-1];
      assign src_cmd = p2_cmd_r[t-1];
      assign src_qa  = p2_qa_r[t-1];
      assign src_ra  = p2_ra_r[t-1];
      assign src_qb  = p2_qb_r[t-1];
      assign src_rb  = p2_rb_r[t-1];
    end

    always_comb begin
      div_a   = (src_cmd == CMD_GROUPED_TO_FLAT) ? ga_r : GA_W'(ch_r);
      trial_a = {src_ra, src_qa[P2-1]};
      diff_a  = trial_a - {1'b0, div_a};
      ge_a    = (trial_a >= {1'b0, div_a});
      trial_b = {src_rb, src_qb[P2-1]};
      diff_b  = trial_b - {1'b0, cw_r};
      ge_b    = (trial_b >= {1'b0, cw_r});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p2_v_r[t] <= 1'b0;
      end else if (en) begin
        p2_v_r[t] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p2_cmd_r[t] <= src_cmd;
        p2_qa_r[t]  <= {src_qa[P2-2:0], ge_a};
        p2_ra_r[t]  <= ge_a ? diff_a[GA_W-1:0] : trial_a[GA_W-1:0];
        p2_qb_r[t]  <= {src_qb[P2-2:0], ge_b};
        p2_rb_r[t]  <= ge_b ? diff_b[CW_W-1:0] : trial_b[CW_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // rebuild: ((qa * a) + qb) * b + ra * cell_width + rb, all modulo 2^17
  //   raster to tile-major: a = groups across, b = cells per tile
  //   tile-major to raster: a = cell height,  b = row length
  // ---------------------------------------------------------------------------
  logic            p2_cmd;
  logic [GA_W-1:0] mul_a;

  assign p2_cmd = p2_cmd_r[P2-1];
  assign mul_a  = (p2_cmd == CMD_GROUPED_TO_FLAT) ? GA_W'(ch_r) : ga_r;

  // stage a: tile row product and in-tile row offset
  logic            s3a_v_r;
  logic            s3a_cmd_r;
  logic [OUT_W-1:0] s3a_pa_r;
  logic [OUT_W-1:0] s3a_qb_r;
  logic [GW_W-1:0] s3a_low_r;
  logic [CW_W-1:0] s3a_rb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3a_v_r <= 1'b0;
    end else if (en) begin
      s3a_v_r <= p2_v_r[P2-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3a_cmd_r <= p2_cmd;
      s3a_pa_r  <= OUT_W'(p2_qa_r[P2-1]) * OUT_W'(mul_a);
      s3a_qb_r  <= OUT_W'(p2_qb_r[P2-1]);
      s3a_low_r <= GW_W'(p2_ra_r[P2-1]) * GW_W'(cw_r);
      s3a_rb_r  <= p2_rb_r[P2-1];
    end
  end

  // stage b: tile number (or raster row) and low part of the result
  logic             s3b_v_r;
  logic             s3b_cmd_r;
  logic [OUT_W-1:0] s3b_tile_r;
  logic [GW_W-1:0]  s3b_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3b_v_r <= 1'b0;
    end else if (en) begin
      s3b_v_r <= s3a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3b_cmd_r  <= s3a_cmd_r;
      s3b_tile_r <= s3a_pa_r + s3a_qb_r;
      s3b_low_r  <= s3a_low_r + GW_W'(s3a_rb_r);
    end
  end

  // stage c: scale by cells per tile or row length
  logic [GW_W-1:0]  mul_b;
  logic             s3c_v_r;
  logic [OUT_W-1:0] s3c_hi_r;
  logic [GW_W-1:0]  s3c_low_r;

  assign mul_b = (s3b_cmd_r == CMD_GROUPED_TO_FLAT) ? gw_r : GW_W'(wh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3c_v_r <= 1'b0;
    end else if (en) begin
      s3c_v_r <= s3b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3c_hi_r  <= s3b_tile_r * OUT_W'(mul_b);
      s3c_low_r <= s3b_low_r;
    end
  end

  // stage d: final sum
  logic             s3d_v_r;
  logic [OUT_W-1:0] s3d_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3d_v_r <= 1'b0;
    end else if (en) begin
      s3d_v_r <= s3c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3d_res_r <= s3c_hi_r + OUT_W'(s3c_low_r);
    end
  end

  // ---------------------------------------------------------------------------
  // output register plus one-entry skid register
  // ---------------------------------------------------------------------------
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] skid_data_r;
  logic             out_free;

  // output slot is empty or being taken this cycle
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= s3d_v_r;
      end
    end else if (s3d_v_r && en) begin
      // result arrives while the output holds: park it
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_v_r ? skid_data_r : s3d_res_r;
    end
    if (!out_free && en) begin
      skid_data_r <= s3d_res_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_index = out_data_r;

endmodule
